// ----- rtl/bcs_pkg.sv -----
// Shared types and constants for the batch cosine similarity block.
// Used by the front end, the job queue and the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bcs_pkg;

  localparam int QueueDepth = 4;
  localparam int QueueLevelW = $clog2(QueueDepth + 1);

  localparam logic [31:0] OneQ24 = 32'd16777216;
  localparam logic [31:0] UnitTol = 32'd1677;
  localparam logic [63:0] DenomMin = 64'd281474;

  // Configuration register indexes.
  localparam logic CfgVectorLength = 1'b0;
  localparam logic CfgBatchCount   = 1'b1;

  // One finished vector handed from the front end to the back end.
  typedef struct packed {
    logic               is_cand;
    logic signed [47:0] dot;
    logic [47:0]        sq;
    logic [15:0]        index;
    logic               done;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/bcs_fifo.sv -----
// Short job queue between the element front end and the arithmetic back end.
// Depends on bcs_pkg for the job word type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none
module bcs_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire bcs_pkg::job_t                  push_job,
  input  wire logic                           pop,
  output bcs_pkg::job_t                       head_job,
  output logic                                empty,
  output logic [bcs_pkg::QueueLevelW-1:0]     level
);

  localparam int PW = (bcs_pkg::QueueDepth > 1) ? $clog2(bcs_pkg::QueueDepth) : 1;

  bcs_pkg::job_t slots [bcs_pkg::QueueDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign empty    = (level == '0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(bcs_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(bcs_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bcs_front.sv -----
// Front end: takes element words, keeps the query store, accumulates the dot
// product and the sum of squares, and queues one job per finished vector.
// Depends on bcs_pkg for the job word type and the queue constants.
`timescale 1ns / 1ps
`default_nettype none
module bcs_front #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            operation,
  input  wire logic signed [15:0]              element_value,
  input  wire logic [10:0]                     vector_length,
  input  wire logic [15:0]                     batch_count,
  input  wire logic [bcs_pkg::QueueLevelW-1:0] queue_level,
  output logic                                 push,
  output bcs_pkg::job_t                        push_job
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW = $clog2(MAX_DIM + 1) + 1;

  logic signed [15:0] qmem [MAX_DIM];

  logic [AW-1:0] pos;
  logic          query_ready;
  logic [15:0]   vcount;

  logic [LW-1:0] len;
  logic [16:0]   cnt;
  logic          accept;
  logic [AW-1:0] pos_eff;
  logic          last;
  logic          done;

  logic               b_valid;
  logic               b_cand;
  logic               b_first;
  logic               b_last;
  logic signed [15:0] b_x;
  logic signed [15:0] b_q;
  logic [15:0]        b_index;
  logic               b_done;

  logic signed [47:0] dot;
  logic [47:0]        sq;
  logic signed [31:0] dprod;
  logic signed [31:0] sprod;
  logic signed [47:0] dot_next;
  logic [47:0]        sq_next;

  // One slot is held back for the element already in the accumulate stage.
  assign in_stall = (queue_level >= bcs_pkg::QueueLevelW'(bcs_pkg::QueueDepth - 1));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (vector_length == 11'd0) begin
      len = LW'(1);
    end else if (32'(vector_length) > 32'(MAX_DIM)) begin
      len = LW'(MAX_DIM);
    end else begin
      len = LW'(vector_length);
    end
    cnt     = (batch_count == 16'd0) ? 17'd1 : {1'b0, batch_count};
    pos_eff = (!operation && query_ready) ? '0 : pos;
    last    = (LW'(pos_eff) + LW'(1)) >= len;
    done    = ({1'b0, vcount} + 17'd1) >= cnt;
  end

  always_ff @(posedge clk) begin
    if (accept && !operation) begin
      qmem[pos_eff] <= element_value;
    end
    if (accept && operation) begin
      b_q <= qmem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      query_ready <= 1'b0;
      vcount      <= '0;
      b_valid     <= 1'b0;
    end else begin
      b_valid <= 1'b0;
      if (accept && !operation) begin
        b_valid <= 1'b1;
        if (last) begin
          query_ready <= 1'b1;
          vcount      <= '0;
          pos         <= '0;
        end else begin
          query_ready <= 1'b0;
          if (query_ready) begin
            vcount <= '0;
          end
          pos <= pos_eff + 1'b1;
        end
      end else if (accept && query_ready) begin
        b_valid <= 1'b1;
        if (last) begin
          pos    <= '0;
          vcount <= done ? '0 : vcount + 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_cand  <= operation;
      b_first <= (pos_eff == '0);
      b_last  <= last;
      b_x     <= element_value;
      b_index <= vcount;
      b_done  <= done;
    end
  end

  always_comb begin
    dprod    = b_cand ? b_q * b_x : 32'sd0;
    sprod    = b_x * b_x;
    dot_next = (b_first ? 48'sd0 : dot) + 48'(dprod);
    sq_next  = (b_first ? 48'd0 : sq) + {16'd0, 32'(unsigned'(sprod))};
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      dot <= dot_next;
      sq  <= sq_next;
    end
  end

  assign push             = b_valid && b_last;
  assign push_job.is_cand = b_cand;
  assign push_job.dot     = dot_next;
  assign push_job.sq      = sq_next;
  assign push_job.index   = b_index;
  assign push_job.done    = b_done;

endmodule
`default_nettype wire

// ----- rtl/bcs_back.sv -----
// Back end: square root of a sum of squares, norm product and long division,
// one result bit per cycle, feeding the output register.
// Depends on bcs_pkg for the job word type and the fixed-point constants.
`timescale 1ns / 1ps
`default_nettype none
module bcs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          queue_empty,
  input  wire bcs_pkg::job_t head_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic signed [31:0] similarity,
  output logic [15:0]        vector_index,
  output logic               batch_done
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_MUL, S_CHECK, S_DIV, S_ROUND, S_OUT
  } state_t;

  state_t        state;
  bcs_pkg::job_t job;
  logic [31:0]   qnorm;
  logic          qunit;
  logic [63:0]   sx;
  logic [63:0]   sr;
  logic [63:0]   sbit;
  logic [5:0]    step;
  logic [63:0]   prod;
  logic [63:0]   rem;
  logic [42:0]   quo;
  logic [31:0]   res;

  logic          neg;
  logic [47:0]   mag;
  logic          h_neg;
  logic [47:0]   h_mag;
  logic [63:0]   s_try;
  logic          s_take;
  logic [63:0]   s_x_next;
  logic [63:0]   s_r_next;
  logic [64:0]   d_shift;
  logic          d_take;
  logic [42:0]   q_round;

  function automatic logic [31:0] sat_signed(input logic is_neg, input logic [63:0] m);
    logic [31:0] r;
    if (is_neg) begin
      r = (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - m[31:0]);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  always_comb begin
    neg      = job.dot[47];
    mag      = neg ? 48'(-job.dot) : 48'(job.dot);
    h_neg    = head_job.dot[47];
    h_mag    = h_neg ? 48'(-head_job.dot) : 48'(head_job.dot);
    s_try    = sr + sbit;
    s_take   = (sx >= s_try);
    s_x_next = s_take ? sx - s_try : sx;
    s_r_next = s_take ? (sr >> 1) + sbit : (sr >> 1);
    d_shift  = {rem, 1'b0};
    d_take   = (d_shift >= {1'b0, prod});
    q_round  = quo + 43'((rem >= prod - rem) ? 1 : 0);
  end

  assign pop = (state == S_IDLE) && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qnorm     <= '0;
      qunit     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In the output state the register is reloaded below instead.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            job <= head_job;
            if (head_job.is_cand && qunit) begin
              res   <= sat_signed(h_neg, 64'((h_mag + 48'd32) >> 6));
              state <= S_OUT;
            end else if (head_job.sq >= 48'h4000_0000_0000) begin
              sr <= 64'h0000_0000_FFFF_FFFF;
              if (head_job.is_cand) begin
                state <= S_MUL;
              end else begin
                qnorm <= 32'hFFFF_FFFF;
                qunit <= 1'b0;
              end
            end else begin
              sx    <= {head_job.sq[45:0], 18'd0};
              sr    <= '0;
              sbit  <= 64'h4000_0000_0000_0000;
              step  <= '0;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          sx   <= s_x_next;
          sr   <= s_r_next;
          sbit <= sbit >> 2;
          step <= step + 1'b1;
          if (step == 6'd31) begin
            if (job.is_cand) begin
              state <= S_MUL;
            end else begin
              qnorm <= s_r_next[31:0];
              qunit <= (s_r_next[31:0] >= bcs_pkg::OneQ24 - bcs_pkg::UnitTol) &&
                       (s_r_next[31:0] <= bcs_pkg::OneQ24 + bcs_pkg::UnitTol);
              state <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          prod  <= 64'(qnorm) * 64'(sr[31:0]);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (prod <= bcs_pkg::DenomMin) begin
            res   <= '0;
            state <= S_OUT;
          end else if ({5'd0, mag, 11'd0} >= prod) begin
            res   <= sat_signed(neg, 64'h0000_0100_0000_0000);
            state <= S_OUT;
          end else begin
            rem   <= {16'd0, mag};
            quo   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= d_take ? 64'(d_shift - {1'b0, prod}) : d_shift[63:0];
          quo  <= {quo[41:0], d_take};
          step <= step + 1'b1;
          if (step == 6'd41) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          res   <= sat_signed(neg, {21'd0, q_round});
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            similarity   <= res;
            vector_index <= job.index;
            batch_done   <= job.done;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/batch_cosine_similarity.sv -----
// Batch cosine similarity: Q1.15 elements in, one Q7.24 result per candidate.
// The front end takes one element word per cycle while in_stall is low and
// pushes a vector's job into the queue in the cycle after its last element is
// accepted. The back end pops a job only when idle; a norm takes a 32-step root
// and a cosine takes a root and a 42-step divide, or neither if query is unit.
// Synchronous reset clears control state; length becomes 128 and batch count 1.
`timescale 1ns / 1ps
`default_nettype none
module batch_cosine_similarity #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic signed [15:0] element_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      similarity,
  output logic [15:0]             vector_index,
  output logic                    batch_done,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic [10:0] vector_length;
  logic [15:0] batch_count;

  logic                            push;
  bcs_pkg::job_t                   push_job;
  logic                            pop;
  bcs_pkg::job_t                   head_job;
  logic                            queue_empty;
  logic [bcs_pkg::QueueLevelW-1:0] queue_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= 11'd128;
      batch_count   <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcs_pkg::CfgVectorLength: vector_length <= cfg_data[10:0];
        bcs_pkg::CfgBatchCount:   batch_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  bcs_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .element_value(element_value),
    .vector_length(vector_length),
    .batch_count  (batch_count),
    .queue_level  (queue_level),
    .push         (push),
    .push_job     (push_job)
  );

  bcs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .empty   (queue_empty),
    .level   (queue_level)
  );

  bcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .similarity  (similarity),
    .vector_index(vector_index),
    .batch_done  (batch_done)
  );

endmodule
`default_nettype wire
